[rtl/kca_pkg.sv]
// kca_pkg: shared types, key table and constants for the key click and
// autorepeat core. No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package kca_pkg;

  // Key table size and index widths
  localparam int NUM_KEYS  = 14;
  localparam int KEY_W     = 4;
  localparam int WORD_W    = 32;
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 1'd1;

  // Configuration reset values
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd175;

  // Input action codes
  localparam logic ACT_SCAN   = 1'b0;
  localparam logic ACT_FORGET = 1'b1;

  // "No key" index
  localparam logic [KEY_W-1:0] KEY_NONE = '0;

  // Key table: group select (1 = word 1) and active-low mask per key
  localparam logic [NUM_KEYS-1:0] KEY_GROUP = 14'b00_1111_1111_1111;

  localparam logic [WORD_W-1:0] KEY_MASK [NUM_KEYS] = '{
    32'h0100_0000, 32'h0800_0000, 32'h0008_0000, 32'h0002_0000,
    32'h0004_0000, 32'h0001_0000, 32'h0010_0000, 32'h1000_0000,
    32'h0400_0000, 32'h0200_0000, 32'h0000_0100, 32'h0000_0200,
    32'h0000_000C, 32'h0000_0004
  };

  typedef logic [KEY_W-1:0] key_idx_t;

  // One input request
  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] group0_bits;
    logic [WORD_W-1:0] group1_bits;
    logic [TIME_W-1:0] now_ms;
  } in_req_t;

  // One result request
  typedef struct packed {
    key_idx_t clicked_key;
    key_idx_t repeat_key;
    key_idx_t pressed_key;
  } out_req_t;

  // Decoder status handed to the autorepeat logic
  typedef struct packed {
    key_idx_t pressed;
    key_idx_t clicked;
    logic     held_down;
  } dec_t;

  // A key is down when all of its mask bits are low in its word
  function automatic logic key_pressed_in(input logic [WORD_W-1:0] w0,
                                          input logic [WORD_W-1:0] w1,
                                          input int unsigned k);
    logic [WORD_W-1:0] w;
    begin
      w = KEY_GROUP[k] ? w1 : w0;
      return (w & KEY_MASK[k]) == '0;
    end
  endfunction

endpackage

[rtl/kca_key_decode.sv]
// kca_key_decode: holds the current and previous key status words and
// decodes pressed, clicked and held-key status. Depends on kca_pkg.
`timescale 1ns / 1ps

module kca_key_decode (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     action,
  input  logic [kca_pkg::WORD_W-1:0] group0_bits,
  input  logic [kca_pkg::WORD_W-1:0] group1_bits,
  input  kca_pkg::key_idx_t        held_key,
  output kca_pkg::dec_t            dec
);

  logic [kca_pkg::WORD_W-1:0] cur0_r, cur1_r, prev0_r, prev1_r;
  logic [kca_pkg::WORD_W-1:0] cur0_nxt, cur1_nxt, prev0_nxt, prev1_nxt;

  // Words as seen by this request: a scan shifts, a forget keeps
  always_comb begin
    if (action == kca_pkg::ACT_SCAN) begin
      cur0_nxt  = group0_bits;
      cur1_nxt  = group1_bits;
      prev0_nxt = cur0_r;
      prev1_nxt = cur1_r;
    end else begin
      cur0_nxt  = cur0_r;
      cur1_nxt  = cur1_r;
      prev0_nxt = prev0_r;
      prev1_nxt = prev1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur0_r  <= '0;
      cur1_r  <= '0;
      prev0_r <= '0;
      prev1_r <= '0;
    end else if (en) begin
      cur0_r  <= cur0_nxt;
      cur1_r  <= cur1_nxt;
      prev0_r <= prev0_nxt;
      prev1_r <= prev1_nxt;
    end
  end

  // Priority match in table order; held key looked up in the same pass
  always_comb begin
    dec = '0;
    for (int unsigned k = 0; k < kca_pkg::NUM_KEYS; k++) begin
      if (kca_pkg::key_pressed_in(cur0_nxt, cur1_nxt, k)) begin
        if (dec.pressed == kca_pkg::KEY_NONE)
          dec.pressed = kca_pkg::KEY_W'(k + 1);
        if (!kca_pkg::key_pressed_in(prev0_nxt, prev1_nxt, k) &&
            dec.clicked == kca_pkg::KEY_NONE)
          dec.clicked = kca_pkg::KEY_W'(k + 1);
        if (held_key == kca_pkg::KEY_W'(k + 1))
          dec.held_down = 1'b1;
      end
    end
  end

endmodule

[rtl/kca_repeat.sv]
// kca_repeat: autorepeat state, delay registers and elapsed-time compare.
// Depends on kca_pkg; takes decoder status from kca_key_decode.
`timescale 1ns / 1ps

module kca_repeat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kca_pkg::DELAY_W-1:0]   cfg_data,
  input  logic                          en,
  input  logic                          action,
  input  logic [kca_pkg::TIME_W-1:0]    now_ms,
  input  kca_pkg::dec_t                 dec,
  output kca_pkg::key_idx_t             held_key,
  output kca_pkg::key_idx_t             repeat_key
);

  logic [kca_pkg::DELAY_W-1:0] first_delay_r, repeat_delay_r;
  kca_pkg::key_idx_t           held_r, held_nxt;
  logic [kca_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic                        repeating_r, repeating_nxt;
  logic [kca_pkg::TIME_W-1:0]  elapsed;
  logic [kca_pkg::DELAY_W-1:0] limit;
  logic                        fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r  <= kca_pkg::FIRST_DELAY_RST;
      repeat_delay_r <= kca_pkg::REPEAT_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kca_pkg::CFG_FIRST_DELAY:  first_delay_r  <= cfg_data;
        kca_pkg::CFG_REPEAT_DELAY: repeat_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wrapping elapsed time; negative (top bit set) never fires
  assign elapsed = now_ms - last_r;
  assign limit   = repeating_r ? repeat_delay_r : first_delay_r;
  assign fire    = !elapsed[kca_pkg::TIME_W-1] &&
                   (elapsed > kca_pkg::TIME_W'(limit));

  // Next autorepeat state and event key
  always_comb begin
    held_nxt      = held_r;
    last_nxt      = last_r;
    repeating_nxt = repeating_r;
    repeat_key    = kca_pkg::KEY_NONE;
    if (action == kca_pkg::ACT_FORGET) begin
      held_nxt = kca_pkg::KEY_NONE;
    end else if (dec.clicked != kca_pkg::KEY_NONE) begin
      held_nxt      = dec.clicked;
      repeating_nxt = 1'b0;
      last_nxt      = now_ms;
      repeat_key    = dec.clicked;
    end else if (dec.held_down) begin
      if (fire) begin
        repeating_nxt = 1'b1;
        last_nxt      = now_ms;
        repeat_key    = held_r;
      end
    end else begin
      held_nxt = kca_pkg::KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= kca_pkg::KEY_NONE;
      last_r      <= '0;
      repeating_r <= 1'b0;
    end else if (en) begin
      held_r      <= held_nxt;
      last_r      <= last_nxt;
      repeating_r <= repeating_nxt;
    end
  end

  assign held_key = held_r;

endmodule

[rtl/key_click_autorepeat_core.sv]
// Key click and autorepeat core: an accepted input request is held in the
// input register, and its result is written to the result register and shown
// on out_req; one request per cycle sustained while out_stall stays low.
// The input register feeds one pass of key decode and repeat-timer compare
// into the result register. Reset (rst_n low, synchronous) clears all key
// words, the held key and timer, and loads delays 500 ms and 175 ms.
// Depends on kca_pkg, kca_key_decode and kca_repeat.
`timescale 1ns / 1ps

module key_click_autorepeat_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kca_pkg::DELAY_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kca_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kca_pkg::out_req_t             out_req
);

  logic              s1_valid_r, s1_valid_nxt;
  kca_pkg::in_req_t  s1_req_r;
  logic              out_valid_r, out_valid_nxt;
  kca_pkg::out_req_t out_req_r;
  logic              s2_ready;
  logic              proc;
  kca_pkg::dec_t     dec;
  kca_pkg::key_idx_t held_key;
  kca_pkg::key_idx_t repeat_key;

  // Handshake: result register frees up when empty or being taken
  assign s2_ready = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  // Input register
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else
      s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      s1_req_r <= in_req;
  end

  // Key decode and word history
  kca_key_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (proc),
    .action      (s1_req_r.action),
    .group0_bits (s1_req_r.group0_bits),
    .group1_bits (s1_req_r.group1_bits),
    .held_key    (held_key),
    .dec         (dec)
  );

  // Autorepeat state and timing
  kca_repeat u_repeat (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .en         (proc),
    .action     (s1_req_r.action),
    .now_ms     (s1_req_r.now_ms),
    .dec        (dec),
    .held_key   (held_key),
    .repeat_key (repeat_key)
  );

  // Result register
  always_comb begin
    if (proc)
      out_valid_nxt = 1'b1;
    else if (!out_stall)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_req_r.clicked_key <= dec.clicked;
      out_req_r.repeat_key  <= repeat_key;
      out_req_r.pressed_key <= dec.pressed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule
